// ===== rtl/arpc_pkg.sv =====
// Shared types and codes for the ARP cache and responder.
package arpc_pkg;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int AOP_W  = 16;
  localparam int STAT_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [1:0] OPC_RX_ARP  = 2'd0;
  localparam logic [1:0] OPC_ADD     = 2'd1;
  localparam logic [1:0] OPC_DELETE  = 2'd2;
  localparam logic [1:0] OPC_RESOLVE = 2'd3;

  localparam logic [AOP_W-1:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [AOP_W-1:0] ARP_OP_REPLY   = 16'd2;

  localparam logic [1:0] TX_OP_REQUEST = 2'd1;
  localparam logic [1:0] TX_OP_REPLY   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_HIT       = 3'd1;
  localparam logic [STAT_W-1:0] ST_MISS      = 3'd2;
  localparam logic [STAT_W-1:0] ST_DEL_NF    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_RECORD = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DYN_MODE = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_SET_MAC,
    CMD_INSERT,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    logic             live;
    logic [IP_W-1:0]  ip;
    logic             prt;
    logic             use_port;
    logic             hit;
    logic             free;
    logic [MAC_W-1:0] mac;
  } tok_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic             prt;
  } cmd_t;

endpackage

// ===== rtl/arpc_cell.sv =====
// One table entry: compares the passing search token and applies write-back commands.
module arpc_cell
  import arpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_in,
  input  cmd_t cmd,
  output tok_t tok_out
);

  logic             valid_r;
  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;
  logic             port_r;
  logic             hit_claim_r;
  logic             free_claim_r;
  tok_t             tok_r;
  tok_t             tok_nxt;
  logic             entry_match;

  assign entry_match = valid_r && (ip_r == tok_in.ip) &&
                       (!tok_in.use_port || (port_r == tok_in.prt));

  always_comb begin
    tok_nxt = tok_in;
    if (entry_match && !tok_in.hit) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.mac = mac_r;
    end
    if (!valid_r && !tok_in.free) begin
      tok_nxt.free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.live   <= 1'b0;
      hit_claim_r  <= 1'b0;
      free_claim_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (tok_in.live) begin
        hit_claim_r  <= entry_match && !tok_in.hit;
        free_claim_r <= !valid_r && !tok_in.free;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (cmd.kind)
        CMD_INSERT: if (free_claim_r) valid_r <= 1'b1;
        CMD_CLEAR:  if (hit_claim_r) valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.kind)
      CMD_SET_MAC: begin
        if (hit_claim_r) mac_r <= cmd.mac;
      end
      CMD_INSERT: begin
        if (free_claim_r) begin
          ip_r   <= cmd.ip;
          mac_r  <= cmd.mac;
          port_r <= cmd.prt;
        end
      end
      default: ;
    endcase
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/arpc_ctrl.sv =====
// Sequencer: item capture, token launch, result decode, write-back and output register.
module arpc_ctrl
  import arpc_pkg::*;
#(
  parameter int PORT_COUNT = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic                  in_port,
  input  logic [AOP_W-1:0]      in_arp_operation,
  input  logic [IP_W-1:0]       in_sender_ip,
  input  logic [MAC_W-1:0]      in_sender_mac,
  input  logic [IP_W-1:0]       in_target_ip,
  input  logic                  in_cache_only,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     out_status,
  output logic                  out_tx_valid,
  output logic [1:0]            out_tx_operation,
  output logic                  out_tx_port,
  output logic [MAC_W-1:0]      out_tx_sender_mac,
  output logic [IP_W-1:0]       out_tx_sender_ip,
  output logic [MAC_W-1:0]      out_tx_target_mac,
  output logic [IP_W-1:0]       out_tx_target_ip,
  output logic [MAC_W-1:0]      out_resolved_mac,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output tok_t                  tok_launch,
  input  tok_t                  tok_tail,
  output cmd_t                  cmd
);

  ctrl_state_t state_r, state_nxt;

  logic [IP_W-1:0]  own_ip0_r, own_ip1_r;
  logic [MAC_W-1:0] own_mac0_r, own_mac1_r;
  logic             dyn_mode_r;

  logic [1:0]       opc_r;
  logic             prt_r;
  logic [AOP_W-1:0] aop_r;
  logic [IP_W-1:0]  sip_r;
  logic [MAC_W-1:0] smac_r;
  logic [IP_W-1:0]  tip_r;
  logic             co_r;
  tok_t             launch_r;
  tok_t             tail_r;

  logic             in_beat;
  logic             load;
  logic             prt_in;
  logic [IP_W-1:0]  key_in;
  logic             use_port_in;
  logic [IP_W-1:0]  own_ip;
  logic [MAC_W-1:0] own_mac;
  logic             is_learn;

  logic [STAT_W-1:0] res_status;
  logic              res_tx_valid;
  logic [1:0]        res_tx_op;
  logic [MAC_W-1:0]  res_tx_smac;
  logic [IP_W-1:0]   res_tx_sip;
  logic [MAC_W-1:0]  res_tx_tmac;
  logic [IP_W-1:0]   res_tx_tip;
  logic [MAC_W-1:0]  res_rmac;
  cmd_kind_t         res_cmd;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r;
  logic              tx_valid_r;
  logic [1:0]        tx_op_r;
  logic              tx_port_r;
  logic [MAC_W-1:0]  tx_smac_r;
  logic [IP_W-1:0]   tx_sip_r;
  logic [MAC_W-1:0]  tx_tmac_r;
  logic [IP_W-1:0]   tx_tip_r;
  logic [MAC_W-1:0]  rmac_r;

  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && !in_stall;
  assign prt_in    = (32'(in_port) >= PORT_COUNT) ? 1'(PORT_COUNT - 1) : in_port;

  always_comb begin
    case (in_opcode)
      OPC_RESOLVE: begin
        key_in      = in_target_ip;
        use_port_in = 1'b1;
      end
      OPC_DELETE: begin
        key_in      = in_sender_ip;
        use_port_in = 1'b1;
      end
      default: begin
        key_in      = in_sender_ip;
        use_port_in = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip0_r  <= '0;
      own_mac0_r <= '0;
      own_ip1_r  <= '0;
      own_mac1_r <= '0;
      dyn_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_IP0:  own_ip0_r  <= cfg_data[IP_W-1:0];
        CFG_OWN_MAC0: own_mac0_r <= cfg_data[MAC_W-1:0];
        CFG_OWN_IP1:  own_ip1_r  <= cfg_data[IP_W-1:0];
        CFG_OWN_MAC1: own_mac1_r <= cfg_data[MAC_W-1:0];
        CFG_DYN_MODE: dyn_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      opc_r  <= in_opcode;
      prt_r  <= prt_in;
      aop_r  <= in_arp_operation;
      sip_r  <= in_sender_ip;
      smac_r <= in_sender_mac;
      tip_r  <= in_target_ip;
      co_r   <= in_cache_only;
    end
    if (tok_tail.live) begin
      tail_r <= tok_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r.live <= 1'b0;
      state_r       <= S_IDLE;
    end else begin
      launch_r.live <= in_beat;
      state_r       <= state_nxt;
    end
    if (in_beat) begin
      launch_r.ip       <= key_in;
      launch_r.prt      <= prt_in;
      launch_r.use_port <= use_port_in;
      launch_r.hit      <= 1'b0;
      launch_r.free     <= 1'b0;
      launch_r.mac      <= '0;
    end
  end

  assign tok_launch = launch_r;

  assign own_ip  = prt_r ? own_ip1_r : own_ip0_r;
  assign own_mac = prt_r ? own_mac1_r : own_mac0_r;
  assign is_learn = (opc_r == OPC_ADD) ||
                    ((opc_r == OPC_RX_ARP) && (aop_r == ARP_OP_REPLY));

  always_comb begin
    res_status   = ST_DONE;
    res_tx_valid = 1'b0;
    res_tx_op    = '0;
    res_tx_smac  = '0;
    res_tx_sip   = '0;
    res_tx_tmac  = '0;
    res_tx_tip   = '0;
    res_rmac     = '0;
    res_cmd      = CMD_NONE;
    if (is_learn) begin
      if (tail_r.hit) begin
        res_cmd = CMD_SET_MAC;
      end else if (tail_r.free) begin
        res_cmd = CMD_INSERT;
      end else begin
        res_status = ST_FULL;
      end
    end else if (opc_r == OPC_RX_ARP) begin
      if ((aop_r == ARP_OP_REQUEST) && (tip_r == own_ip)) begin
        res_tx_valid = 1'b1;
        res_tx_op    = TX_OP_REPLY;
        res_tx_smac  = own_mac;
        res_tx_sip   = tip_r;
        res_tx_tmac  = smac_r;
        res_tx_tip   = sip_r;
      end
    end else if (opc_r == OPC_DELETE) begin
      if (tail_r.hit) begin
        res_cmd = CMD_CLEAR;
      end else begin
        res_status = ST_DEL_NF;
      end
    end else begin
      if (tail_r.hit) begin
        res_status = ST_HIT;
        res_rmac   = tail_r.mac;
      end else if (co_r) begin
        res_status = ST_MISS;
      end else if (dyn_mode_r) begin
        res_status   = ST_MISS;
        res_tx_valid = 1'b1;
        res_tx_op    = TX_OP_REQUEST;
        res_tx_smac  = own_mac;
        res_tx_sip   = own_ip;
        res_tx_tip   = tip_r;
      end else begin
        res_status = ST_NO_RECORD;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_beat) state_nxt = S_SEARCH;
      S_SEARCH: if (tok_tail.live) state_nxt = S_FINISH;
      S_FINISH: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    load     = 1'b0;
    cmd.kind = CMD_NONE;
    cmd.ip   = sip_r;
    cmd.mac  = smac_r;
    cmd.prt  = prt_r;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_SEARCH: ;
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          load     = 1'b1;
          cmd.kind = res_cmd;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r   <= res_status;
      tx_valid_r <= res_tx_valid;
      tx_op_r    <= res_tx_op;
      tx_port_r  <= res_tx_valid ? prt_r : 1'b0;
      tx_smac_r  <= res_tx_smac;
      tx_sip_r   <= res_tx_sip;
      tx_tmac_r  <= res_tx_tmac;
      tx_tip_r   <= res_tx_tip;
      rmac_r     <= res_rmac;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_tx_valid      = tx_valid_r;
  assign out_tx_operation  = tx_op_r;
  assign out_tx_port       = tx_port_r;
  assign out_tx_sender_mac = tx_smac_r;
  assign out_tx_sender_ip  = tx_sip_r;
  assign out_tx_target_mac = tx_tmac_r;
  assign out_tx_target_ip  = tx_tip_r;
  assign out_resolved_mac  = rmac_r;

endmodule

// ===== rtl/arp_cache_and_responder_core.sv =====
// Top level of the ARP cache and responder: sequencer plus a chain of table cells.
//
//  channel | direction | handshake          | beat contents
//  in_     | in        | in_valid/in_stall   | opcode, port, ARP op, sender/target addresses
//  out_    | out       | out_valid/out_stall | status, ARP packet to send, resolved MAC
//  cfg_    | in        | cfg_valid/cfg_ready | register index, write data
//
// After acceptance the search token walks the chain one cell per cycle, and the result is
// then decoded, written back and loaded into the output register.
// A new item is accepted once the previous result sits in the output register.
// Reset empties the table at once; no clearing pass. cfg_ready is always high.
// out_stall holds the result register; the next item still runs up to write-back.
module arp_cache_and_responder_core
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int PORT_COUNT    = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic                  in_port,
  input  logic [AOP_W-1:0]      in_arp_operation,
  input  logic [IP_W-1:0]       in_sender_ip,
  input  logic [MAC_W-1:0]      in_sender_mac,
  input  logic [IP_W-1:0]       in_target_ip,
  input  logic                  in_cache_only,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     out_status,
  output logic                  out_tx_valid,
  output logic [1:0]            out_tx_operation,
  output logic                  out_tx_port,
  output logic [MAC_W-1:0]      out_tx_sender_mac,
  output logic [IP_W-1:0]       out_tx_sender_ip,
  output logic [MAC_W-1:0]      out_tx_target_mac,
  output logic [IP_W-1:0]       out_tx_target_ip,
  output logic [MAC_W-1:0]      out_resolved_mac,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tok_t tok [TABLE_ENTRIES+1];
  cmd_t cmd;

  arpc_ctrl #(
    .PORT_COUNT(PORT_COUNT)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_port           (in_port),
    .in_arp_operation  (in_arp_operation),
    .in_sender_ip      (in_sender_ip),
    .in_sender_mac     (in_sender_mac),
    .in_target_ip      (in_target_ip),
    .in_cache_only     (in_cache_only),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_tx_valid      (out_tx_valid),
    .out_tx_operation  (out_tx_operation),
    .out_tx_port       (out_tx_port),
    .out_tx_sender_mac (out_tx_sender_mac),
    .out_tx_sender_ip  (out_tx_sender_ip),
    .out_tx_target_mac (out_tx_target_mac),
    .out_tx_target_ip  (out_tx_target_ip),
    .out_resolved_mac  (out_resolved_mac),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .tok_launch        (tok[0]),
    .tok_tail          (tok[TABLE_ENTRIES]),
    .cmd               (cmd)
  );

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[g]),
      .cmd     (cmd),
      .tok_out (tok[g+1])
    );
  end

endmodule

// ===== rtl/arpc_checker.sv =====
// Port-level checks for the ARP cache and responder, bound to the top level.
module arpc_checker
  import arpc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] out_status,
  input logic              out_tx_valid,
  input logic [1:0]        out_tx_operation,
  input logic              out_tx_port,
  input logic [MAC_W-1:0]  out_tx_sender_mac,
  input logic [IP_W-1:0]   out_tx_sender_ip,
  input logic [MAC_W-1:0]  out_tx_target_mac,
  input logic [IP_W-1:0]   out_tx_target_ip,
  input logic [MAC_W-1:0]  out_resolved_mac
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  a_tx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_operation == '0 && out_tx_port == 1'b0 &&
      out_tx_sender_mac == '0 && out_tx_sender_ip == '0 &&
      out_tx_target_mac == '0 && out_tx_target_ip == '0)
    else $error("packet fields set without a packet");

  a_rmac_hit_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_HIT |-> out_resolved_mac == '0)
    else $error("resolved MAC without a hit");

  a_tx_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |->
      (out_tx_operation == TX_OP_REQUEST && out_tx_target_mac == '0 &&
        out_status == ST_MISS) ||
      (out_tx_operation == TX_OP_REPLY && out_status == ST_DONE))
    else $error("malformed outgoing packet");

endmodule

bind arp_cache_and_responder_core arpc_checker u_arpc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_tx_valid      (out_tx_valid),
  .out_tx_operation  (out_tx_operation),
  .out_tx_port       (out_tx_port),
  .out_tx_sender_mac (out_tx_sender_mac),
  .out_tx_sender_ip  (out_tx_sender_ip),
  .out_tx_target_mac (out_tx_target_mac),
  .out_tx_target_ip  (out_tx_target_ip),
  .out_resolved_mac  (out_resolved_mac)
);

// ===== bench/arp_cache_and_responder_core_tb.sv =====
// Self-checking testbench for the ARP cache and responder core.
module arp_cache_and_responder_core_tb;
  import arpc_pkg::*;

  localparam int N_BIND      = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 300;

  typedef struct packed {
    logic [1:0]       opcode;
    logic             port;
    logic [AOP_W-1:0] aop;
    logic [IP_W-1:0]  sip;
    logic [MAC_W-1:0] smac;
    logic [IP_W-1:0]  tip;
    logic             cache_only;
  } arp_query_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              tx_valid;
    logic [1:0]        tx_op;
    logic              tx_port;
    logic [MAC_W-1:0]  tx_smac;
    logic [IP_W-1:0]   tx_sip;
    logic [MAC_W-1:0]  tx_tmac;
    logic [IP_W-1:0]   tx_tip;
    logic [MAC_W-1:0]  rmac;
  } arp_answer_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    arp_query_t            q;
    bit                    typed;
    arp_answer_t           ans;
  } script_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_opcode = '0;
  logic                  in_port = 1'b0;
  logic [AOP_W-1:0]      in_arp_operation = '0;
  logic [IP_W-1:0]       in_sender_ip = '0;
  logic [MAC_W-1:0]      in_sender_mac = '0;
  logic [IP_W-1:0]       in_target_ip = '0;
  logic                  in_cache_only = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STAT_W-1:0]     out_status;
  logic                  out_tx_valid;
  logic [1:0]            out_tx_operation;
  logic                  out_tx_port;
  logic [MAC_W-1:0]      out_tx_sender_mac;
  logic [IP_W-1:0]       out_tx_sender_ip;
  logic [MAC_W-1:0]      out_tx_target_mac;
  logic [IP_W-1:0]       out_tx_target_ip;
  logic [MAC_W-1:0]      out_resolved_mac;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  arp_cache_and_responder_core #(
    .TABLE_ENTRIES(N_BIND),
    .PORT_COUNT   (2)
  ) u_top (.*);

  // predictor state
  bit               bind_valid[N_BIND];
  logic [IP_W-1:0]  bind_ip[N_BIND];
  logic [MAC_W-1:0] bind_mac[N_BIND];
  logic             bind_port[N_BIND];
  logic [IP_W-1:0]  host_ip[2];
  logic [MAC_W-1:0] host_mac[2];
  logic             dyn_resolve;

  arp_answer_t   pending_answers[$];
  script_row_t   directed_script[$];
  logic [IP_W-1:0] ip_pool[64];
  int            mismatches = 0;
  int            result_beats = 0;
  int            quiet_cycles = 0;
  int            hold_left = 0;
  bit            hold_request = 1'b0;
  bit            calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return w[MAC_W-1:0];
    endcase
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_OWN_IP0:  host_ip[0]  = val[IP_W-1:0];
      CFG_OWN_MAC0: host_mac[0] = val[MAC_W-1:0];
      CFG_OWN_IP1:  host_ip[1]  = val[IP_W-1:0];
      CFG_OWN_MAC1: host_mac[1] = val[MAC_W-1:0];
      CFG_DYN_MODE: dyn_resolve = val[0];
      default: ;
    endcase
  endfunction

  function automatic logic [STAT_W-1:0] learn_binding(logic [IP_W-1:0] ip,
                                                      logic [MAC_W-1:0] mac,
                                                      logic prt);
    for (int i = 0; i < N_BIND; i++) begin
      if (bind_valid[i] && bind_ip[i] == ip) begin
        bind_mac[i] = mac;
        return ST_DONE;
      end
    end
    for (int i = 0; i < N_BIND; i++) begin
      if (!bind_valid[i]) begin
        bind_valid[i] = 1'b1;
        bind_ip[i]    = ip;
        bind_mac[i]   = mac;
        bind_port[i]  = prt;
        return ST_DONE;
      end
    end
    return ST_FULL;
  endfunction

  function automatic arp_answer_t predict_answer(arp_query_t q);
    arp_answer_t a;
    bit          found;
    a = '0;
    found = 1'b0;
    case (q.opcode)
      OPC_RX_ARP: begin
        if (q.aop == ARP_OP_REPLY) begin
          a.status = learn_binding(q.sip, q.smac, q.port);
        end else if (q.aop == ARP_OP_REQUEST && q.tip == host_ip[q.port]) begin
          a.tx_valid = 1'b1;
          a.tx_op    = TX_OP_REPLY;
          a.tx_port  = q.port;
          a.tx_smac  = host_mac[q.port];
          a.tx_sip   = q.tip;
          a.tx_tmac  = q.smac;
          a.tx_tip   = q.sip;
        end
      end
      OPC_ADD: a.status = learn_binding(q.sip, q.smac, q.port);
      OPC_DELETE: begin
        a.status = ST_DEL_NF;
        for (int i = 0; i < N_BIND; i++) begin
          if (bind_valid[i] && bind_ip[i] == q.sip && bind_port[i] == q.port) begin
            bind_valid[i] = 1'b0;
            a.status = ST_DONE;
            break;
          end
        end
      end
      default: begin
        for (int i = 0; i < N_BIND; i++) begin
          if (bind_valid[i] && bind_ip[i] == q.tip && bind_port[i] == q.port) begin
            found = 1'b1;
            a.status = ST_HIT;
            a.rmac = bind_mac[i];
            break;
          end
        end
        if (!found) begin
          if (q.cache_only) begin
            a.status = ST_MISS;
          end else if (dyn_resolve) begin
            a.status   = ST_MISS;
            a.tx_valid = 1'b1;
            a.tx_op    = TX_OP_REQUEST;
            a.tx_port  = q.port;
            a.tx_smac  = host_mac[q.port];
            a.tx_sip   = host_ip[q.port];
            a.tx_tip   = q.tip;
          end else begin
            a.status = ST_NO_RECORD;
          end
        end
      end
    endcase
    return a;
  endfunction

  function automatic logic [IP_W-1:0] pick_ip(int pool_n);
    if ($urandom_range(9) == 0) return $urandom();
    return ip_pool[$urandom_range(pool_n - 1)];
  endfunction

  function automatic arp_query_t random_query(int pool_n);
    arp_query_t q;
    int         r;
    r = $urandom_range(99);
    if (r < 35)      q.opcode = OPC_RX_ARP;
    else if (r < 55) q.opcode = OPC_ADD;
    else if (r < 70) q.opcode = OPC_DELETE;
    else             q.opcode = OPC_RESOLVE;
    q.port = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 45)      q.aop = ARP_OP_REQUEST;
    else if (r < 90) q.aop = ARP_OP_REPLY;
    else             q.aop = AOP_W'($urandom());
    q.sip  = pick_ip(pool_n);
    q.smac = rand_mac();
    if (q.opcode == OPC_RX_ARP && $urandom_range(1) == 1) q.tip = host_ip[q.port];
    else                                                   q.tip = pick_ip(pool_n);
    q.cache_only = ($urandom_range(3) == 0);
    return q;
  endfunction

  function automatic script_row_t op_row(logic [1:0] opc, logic prt, logic [AOP_W-1:0] aop,
                                         logic [IP_W-1:0] sip, logic [MAC_W-1:0] smac,
                                         logic [IP_W-1:0] tip, logic co);
    script_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_idx = '0;
    r.cfg_val = '0;
    r.q       = '{opc, prt, aop, sip, smac, tip, co};
    r.typed   = 1'b0;
    r.ans     = '0;
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    script_row_t r;
    r = op_row(OPC_RX_ARP, 1'b0, '0, '0, '0, '0, 1'b0);
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic script_row_t checked(script_row_t r, arp_answer_t a);
    r.typed = 1'b1;
    r.ans   = a;
    return r;
  endfunction

  function automatic void add_row(script_row_t r);
    directed_script.insert(directed_script.size(), r);
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
  endtask

  task automatic offer_query(input arp_query_t q, input bit typed, input arp_answer_t fixed);
    arp_answer_t p;
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= q.opcode;
    in_port          <= q.port;
    in_arp_operation <= q.aop;
    in_sender_ip     <= q.sip;
    in_sender_mac    <= q.smac;
    in_target_ip     <= q.tip;
    in_cache_only    <= q.cache_only;
    do @(posedge clk); while (in_stall);
    p = predict_answer(q);
    pending_answers.insert(pending_answers.size(), typed ? fixed : p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", result_beats, field, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    arp_answer_t w;
    if (rst_n && out_valid && !out_stall) begin
      result_beats++;
      if (pending_answers.size() == 0) begin
        flag_mismatch("unexpected beat", 64'(out_status), '0);
      end else begin
        w = pending_answers.pop_front();
        if (out_status !== w.status)
          flag_mismatch("status", 64'(out_status), 64'(w.status));
        if (out_tx_valid !== w.tx_valid)
          flag_mismatch("tx_valid", 64'(out_tx_valid), 64'(w.tx_valid));
        if (out_tx_operation !== w.tx_op)
          flag_mismatch("tx_operation", 64'(out_tx_operation), 64'(w.tx_op));
        if (out_tx_port !== w.tx_port)
          flag_mismatch("tx_port", 64'(out_tx_port), 64'(w.tx_port));
        if (out_tx_sender_mac !== w.tx_smac)
          flag_mismatch("tx_sender_mac", 64'(out_tx_sender_mac), 64'(w.tx_smac));
        if (out_tx_sender_ip !== w.tx_sip)
          flag_mismatch("tx_sender_ip", 64'(out_tx_sender_ip), 64'(w.tx_sip));
        if (out_tx_target_mac !== w.tx_tmac)
          flag_mismatch("tx_target_mac", 64'(out_tx_target_mac), 64'(w.tx_tmac));
        if (out_tx_target_ip !== w.tx_tip)
          flag_mismatch("tx_target_ip", 64'(out_tx_target_ip), 64'(w.tx_tip));
        if (out_resolved_mac !== w.rmac)
          flag_mismatch("resolved_mac", 64'(out_resolved_mac), 64'(w.rmac));
      end
    end
  end

  // result receiver: random stalls, one long hold on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("arp_cache_and_responder_core test failed");
      $finish;
    end
  end

  initial begin
    logic [IP_W-1:0]  ip0, ip1;
    logic [MAC_W-1:0] mac0, mac1;
    logic             dyn;
    int               pool_n;
    int               pool_sizes[PHASES];

    pool_sizes = '{6, 20, 48, 20, 48, 12};
    for (int i = 0; i < N_BIND; i++) bind_valid[i] = 1'b0;
    for (int i = 0; i < 64; i++) ip_pool[i] = $urandom();
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 0; i < 2; i++) begin
      host_ip[i]  = '0;
      host_mac[i] = '0;
    end
    dyn_resolve = 1'b0;

    // reset values: own addresses zero, static mode, empty table
    add_row(checked(
      op_row(OPC_RESOLVE, 1'b0, '0, '0, '0, 32'h0A00_0001, 1'b0),
      '{ST_NO_RECORD, 1'b0, 2'd0, 1'b0, '0, '0, '0, '0, '0}));
    add_row(checked(
      op_row(OPC_RESOLVE, 1'b1, '1, '1, '1, '0, 1'b1),
      '{ST_MISS, 1'b0, 2'd0, 1'b0, '0, '0, '0, '0, '0}));
    add_row(checked(
      op_row(OPC_DELETE, 1'b1, '0, 32'h0A00_0001, '0, '0, 1'b0),
      '{ST_DEL_NF, 1'b0, 2'd0, 1'b0, '0, '0, '0, '0, '0}));
    add_row(checked(
      op_row(OPC_RX_ARP, 1'b0, 16'hFFFF, '1, '1, '1, 1'b0),
      '{ST_DONE, 1'b0, 2'd0, 1'b0, '0, '0, '0, '0, '0}));
    add_row(checked(
      op_row(OPC_RX_ARP, 1'b1, 16'h0000, '0, '0, '0, 1'b1),
      '{ST_DONE, 1'b0, 2'd0, 1'b0, '0, '0, '0, '0, '0}));
    add_row(checked(
      op_row(OPC_RX_ARP, 1'b0, ARP_OP_REQUEST, '1, '1, '0, 1'b0),
      '{ST_DONE, 1'b1, TX_OP_REPLY, 1'b0, '0, '0, '1, '1, '0}));
    add_row(cfg_row(CFG_OWN_IP0, 48'hC0A8_0001));
    add_row(cfg_row(CFG_OWN_MAC0, 48'h0200_0000_0001));
    add_row(cfg_row(CFG_OWN_IP1, 48'hFFFF_FFFF));
    add_row(cfg_row(CFG_OWN_MAC1, '1));
    add_row(cfg_row(CFG_DYN_MODE, 48'd1));
    add_row(op_row(OPC_RX_ARP, 1'b0, ARP_OP_REQUEST, 32'h0A00_0009,
                   48'h1111_2222_3333, 32'hC0A8_0002, 1'b0));
    add_row(op_row(OPC_RX_ARP, 1'b1, ARP_OP_REQUEST, '0, '0, '1, 1'b0));
    add_row(op_row(OPC_RX_ARP, 1'b0, ARP_OP_REPLY, 32'h0A00_0001,
                   48'h1234_5678_9ABC, '0, 1'b0));
    add_row(op_row(OPC_ADD, 1'b1, '0, 32'h0A00_0002, '1, '0, 1'b0));
    add_row(op_row(OPC_ADD, 1'b1, '0, 32'h0A00_0001, '0, '0, 1'b0));
    add_row(op_row(OPC_RESOLVE, 1'b0, '0, '0, '0, 32'h0A00_0001, 1'b0));
    add_row(op_row(OPC_RESOLVE, 1'b1, '0, '0, '0, 32'h0A00_0002, 1'b1));
    add_row(op_row(OPC_RESOLVE, 1'b1, '0, '0, '0, 32'h0A00_0001, 1'b0));
    add_row(op_row(OPC_RESOLVE, 1'b1, '0, '0, '0, 32'h0A00_0001, 1'b1));
    add_row(op_row(OPC_DELETE, 1'b1, '0, 32'h0A00_0001, '0, '0, 1'b0));
    add_row(op_row(OPC_DELETE, 1'b0, '0, 32'h0A00_0001, '0, '0, 1'b0));
    add_row(op_row(OPC_RESOLVE, 1'b0, '0, '0, '0, 32'h0A00_0001, 1'b0));
    add_row(cfg_row(CFG_DYN_MODE, 48'd0));
    add_row(op_row(OPC_ADD, 1'b0, '0, '1, '0, '0, 1'b0));
    add_row(op_row(OPC_RESOLVE, 1'b0, '0, '0, '0, '1, 1'b0));
    add_row(op_row(OPC_RESOLVE, 1'b1, '0, '0, '0, '0, 1'b0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_script[i]) begin
      if (directed_script[i].is_cfg) begin
        drain_results();
        write_register(directed_script[i].cfg_idx, directed_script[i].cfg_val);
      end else begin
        cfg_valid <= 1'b0;
        offer_query(directed_script[i].q, directed_script[i].typed, directed_script[i].ans);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          ip0 = '0; ip1 = '0; mac0 = '0; mac1 = '0; dyn = 1'b0;
        end
        1: begin
          ip0 = '1; ip1 = '1; mac0 = '1; mac1 = '1; dyn = 1'b1;
        end
        default: begin
          ip0  = $urandom();
          ip1  = ($urandom_range(3) == 0) ? ip0 : $urandom();
          mac0 = rand_mac();
          mac1 = rand_mac();
          dyn  = 1'($urandom_range(1));
        end
      endcase
      write_register(CFG_OWN_IP0, {16'd0, ip0});
      write_register(CFG_OWN_MAC0, mac0);
      write_register(CFG_OWN_IP1, {16'd0, ip1});
      write_register(CFG_OWN_MAC1, mac1);
      write_register(CFG_DYN_MODE, {47'd0, dyn});
      cfg_valid <= 1'b0;
      calm   = (ph == 2);
      pool_n = pool_sizes[ph];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain_results();
        if ((ph == 1 || ph == 4) && k == 50) hold_request = 1'b1;
        offer_query(random_query(pool_n), 1'b0, '0);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("arp_cache_and_responder_core test passed");
    else
      $display("arp_cache_and_responder_core test failed");
    $finish;
  end

endmodule
